[sv/hnr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnr_pkg: shared types and constants
// Payload structs, register map and sizing for the height grid resampler.
// ---------------------------------------------------------------------------
package hnr_pkg;

   // Grid sizing
   localparam int MAX_DIM   = 256;
   localparam int IDX_W     = $clog2(MAX_DIM);     // column or row index bits
   localparam int ADDR_W    = 2 * IDX_W;           // store address bits
   localparam int DIM_W     = 9;                   // src_width / src_height
   localparam int COORD_W   = 10;                  // col / row / target_size
   localparam int DVD_W     = IDX_W + COORD_W;     // divider dividend bits
   localparam int DIV_CNT_W = $clog2(IDX_W);       // divider step counter bits
   localparam int HGT_W     = 16;
   localparam int SAMPLE_W  = 32;

   // Clamp limits for the 16-bit signed height
   localparam logic [23:0] POS_LIMIT = 24'd32767;
   localparam logic [23:0] NEG_LIMIT = 24'd32768;

   // Request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Register map (word index)
   localparam logic [1:0] REG_RESIZE_ENABLE = 2'd0;
   localparam logic [1:0] REG_TARGET_SIZE   = 2'd1;
   localparam logic [1:0] REG_SRC_WIDTH     = 2'd2;
   localparam logic [1:0] REG_SRC_HEIGHT    = 2'd3;

   localparam logic [9:0] TARGET_RESET = 10'd257;
   localparam logic [8:0] SRC_RESET    = 9'd256;

   typedef struct packed {
      logic                       mode;
      logic [COORD_W-1:0]         col;
      logic [COORD_W-1:0]         row;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [HGT_W-1:0] height;
      logic                    out_of_range;
   } rsp_type;

endpackage

[sv/hnr_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hnr_div: restoring divider for source index scaling
// Computes dividend / divisor one quotient bit per cycle. The quotient is
// known to fit in IDX_W bits, so the upper dividend bits seed the remainder.
// ---------------------------------------------------------------------------
module hnr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hnr_pkg::DVD_W-1:0]     dividend,
   input  logic [hnr_pkg::COORD_W-1:0]   divisor,
   output logic                          done,
   output logic [hnr_pkg::IDX_W-1:0]     quotient
);

   logic                          busy_ff,  busy_in;
   logic                          done_ff,  done_in;
   logic [hnr_pkg::DIV_CNT_W-1:0] cnt_ff,   cnt_in;
   logic [hnr_pkg::COORD_W-1:0]   rem_ff,   rem_in;
   logic [hnr_pkg::IDX_W-1:0]     low_ff,   low_in;
   logic [hnr_pkg::IDX_W-1:0]     quo_ff,   quo_in;
   logic [hnr_pkg::COORD_W-1:0]   dvs_ff,   dvs_in;

   logic [hnr_pkg::COORD_W:0]     trial;
   logic                          fits;

   // One restoring step
   assign trial = {rem_ff, low_ff[hnr_pkg::IDX_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = hnr_pkg::DIV_CNT_W'(hnr_pkg::IDX_W - 1);
         rem_in  = dividend[hnr_pkg::DVD_W-1 -: hnr_pkg::COORD_W];
         low_in  = dividend[hnr_pkg::IDX_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? hnr_pkg::COORD_W'(trial - {1'b0, dvs_ff})
                       : hnr_pkg::COORD_W'(trial);
         low_in = {low_ff[hnr_pkg::IDX_W-2:0], 1'b0};
         quo_in = {quo_ff[hnr_pkg::IDX_W-2:0], fits};
         cnt_in = cnt_ff - hnr_pkg::DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // Remainder stays below the divisor while stepping
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");

   // Done never overlaps an active step
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

   // Done follows a running divider
   a_done_src: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

endmodule

[sv/heightfield_nearest_resample.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heightfield_nearest_resample: nearest-neighbor height grid resampler
// Holds a 256x256 source height grid in a synchronous RAM. Writes store a
// clamped sample; reads return one cell of a row-flipped, optionally
// resized output grid.
//
//   channel  | signals                           | direction
//   ---------+-----------------------------------+------------------
//   req      | req_valid, req_ready, req_data    | in  (write / read)
//   rsp      | rsp_valid, rsp_ready, rsp_data    | out (one per read)
//   csr      | psel, penable, pwrite, paddr, ... | APB register port
//
// A write is stored at the transfer edge. A resized read: transfer, check,
// 8 divider steps (one quotient bit each, both indexes in parallel), RAM
// read, result load. Other reads: transfer, check (RAM read unless out of
// range), result load. Reset is synchronous and clears control and
// registers; the RAM is not cleared. A stalled result holds in the output
// register and the next request is still taken.
// ---------------------------------------------------------------------------
module heightfield_nearest_resample (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  hnr_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hnr_pkg::rsp_type rsp_data,
   // register port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic                          resize_ff;
   logic [hnr_pkg::COORD_W-1:0]   target_ff;
   logic [hnr_pkg::DIM_W-1:0]     src_w_ff;
   logic [hnr_pkg::DIM_W-1:0]     src_h_ff;
   logic                          csr_wr;
   logic [1:0]                    csr_idx;

   // Request capture and result
   hnr_pkg::req_type              req_ff, req_in;
   logic                          oor_ff, oor_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   hnr_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   // Store
   logic signed [hnr_pkg::HGT_W-1:0] mem [2**hnr_pkg::ADDR_W];
   logic signed [hnr_pkg::HGT_W-1:0] rd_data_ff;
   logic                          rd_en;
   logic [hnr_pkg::ADDR_W-1:0]    rd_addr;
   logic                          wr_en;
   logic [hnr_pkg::ADDR_W-1:0]    wr_addr;
   logic signed [hnr_pkg::HGT_W-1:0] wr_data;

   // Derived values
   logic [hnr_pkg::DIM_W-1:0]     eff_w, eff_h;
   logic                          req_take, rsp_load;
   logic                          oor_chk;
   logic [hnr_pkg::DIM_W-1:0]     flip_row;
   logic [hnr_pkg::COORD_W-1:0]   row_off;
   logic [hnr_pkg::COORD_W+hnr_pkg::DIM_W-1:0] col_prod, row_prod;
   logic                          div_start;
   logic                          col_done, row_done;
   logic [hnr_pkg::IDX_W-1:0]     col_quo, row_quo;

   // Sample conversion
   logic                          s_neg;
   logic [hnr_pkg::SAMPLE_W-1:0]  s_mag;
   logic [23:0]                   s_int;

   // ---------------- register port ----------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         resize_ff <= 1'b0;
         target_ff <= hnr_pkg::TARGET_RESET;
         src_w_ff  <= hnr_pkg::SRC_RESET;
         src_h_ff  <= hnr_pkg::SRC_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            hnr_pkg::REG_RESIZE_ENABLE: resize_ff <= pwdata[0];
            hnr_pkg::REG_TARGET_SIZE:   target_ff <= pwdata[hnr_pkg::COORD_W-1:0];
            hnr_pkg::REG_SRC_WIDTH:     src_w_ff  <= pwdata[hnr_pkg::DIM_W-1:0];
            hnr_pkg::REG_SRC_HEIGHT:    src_h_ff  <= pwdata[hnr_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         hnr_pkg::REG_RESIZE_ENABLE: prdata = {31'd0, resize_ff};
         hnr_pkg::REG_TARGET_SIZE:   prdata = 32'(target_ff);
         hnr_pkg::REG_SRC_WIDTH:     prdata = 32'(src_w_ff);
         hnr_pkg::REG_SRC_HEIGHT:    prdata = 32'(src_h_ff);
         default:                    prdata = '0;
      endcase
   end

   // Effective source size, saturated at the grid limit
   assign eff_w = (src_w_ff > hnr_pkg::DIM_W'(hnr_pkg::MAX_DIM))
                  ? hnr_pkg::DIM_W'(hnr_pkg::MAX_DIM) : src_w_ff;
   assign eff_h = (src_h_ff > hnr_pkg::DIM_W'(hnr_pkg::MAX_DIM))
                  ? hnr_pkg::DIM_W'(hnr_pkg::MAX_DIM) : src_h_ff;

   // ---------------- handshakes ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_READ) && (!rsp_valid_ff || rsp_ready);

   // ---------------- write path ----------------
   // Q23.8 truncated toward zero, clamped to 16-bit signed
   assign s_neg = req_data.sample[hnr_pkg::SAMPLE_W-1];
   assign s_mag = s_neg ? hnr_pkg::SAMPLE_W'(-req_data.sample)
                        : hnr_pkg::SAMPLE_W'(req_data.sample);
   assign s_int = s_mag[hnr_pkg::SAMPLE_W-1:8];

   always_comb begin
      if (s_neg) begin
         wr_data = (s_int > hnr_pkg::NEG_LIMIT) ? -16'sd32768
                                                 : -$signed(s_int[hnr_pkg::HGT_W-1:0]);
      end else begin
         wr_data = (s_int > hnr_pkg::POS_LIMIT) ? 16'sd32767
                                                 : $signed(s_int[hnr_pkg::HGT_W-1:0]);
      end
   end

   assign wr_en = req_take && (req_data.mode == hnr_pkg::MODE_WRITE)
                  && (req_data.col < hnr_pkg::COORD_W'(eff_w))
                  && (req_data.row < hnr_pkg::COORD_W'(eff_h));
   assign wr_addr = {req_data.row[hnr_pkg::IDX_W-1:0], req_data.col[hnr_pkg::IDX_W-1:0]};

   // ---------------- read path: range check and index math ----------------
   always_comb begin
      oor_chk = (eff_w == '0) || (eff_h == '0);
      if (resize_ff) begin
         oor_chk = oor_chk || (target_ff == '0) || (req_ff.col >= target_ff)
                   || (req_ff.row >= target_ff);
      end else begin
         oor_chk = oor_chk || (req_ff.col >= hnr_pkg::COORD_W'(eff_w))
                   || (req_ff.row >= hnr_pkg::COORD_W'(eff_h));
      end
   end

   assign flip_row = eff_h - hnr_pkg::DIM_W'(1) - hnr_pkg::DIM_W'(req_ff.row);
   assign row_off  = target_ff - hnr_pkg::COORD_W'(1) - req_ff.row;
   assign col_prod = req_ff.col * eff_w;
   assign row_prod = row_off * eff_h;

   hnr_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (col_prod[hnr_pkg::DVD_W-1:0]),
      .divisor  (target_ff),
      .done     (col_done),
      .quotient (col_quo)
   );

   hnr_div u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (row_prod[hnr_pkg::DVD_W-1:0]),
      .divisor  (target_ff),
      .done     (row_done),
      .quotient (row_quo)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      oor_in       = oor_ff;
      div_start    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = {flip_row[hnr_pkg::IDX_W-1:0], req_ff.col[hnr_pkg::IDX_W-1:0]};
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in = req_data;
               if (req_data.mode == hnr_pkg::MODE_READ) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            oor_in = oor_chk;
            if (oor_chk) begin
               state_in = ST_READ;
            end else if (resize_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            rd_addr = {row_quo, col_quo};
            if (col_done) begin
               rd_en    = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (rsp_load) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_of_range = oor_ff;
               rsp_data_in.height       = oor_ff ? '0 : rd_data_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- height store ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks ----------------
   // Both index dividers run in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      col_done == row_done)
      else $error("index dividers out of step");

   // Divider results only arrive while the sequencer waits for them
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      col_done |-> state_ff == ST_DIV)
      else $error("divider done outside wait state");

   // Out-of-range results carry a zero height
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.out_of_range |-> rsp_data_ff.height == '0)
      else $error("out-of-range result with nonzero height");

   // Store is never written while a read is in flight
   a_no_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_IDLE)
      else $error("store write outside idle");

endmodule
